// ===== src/aho_corasick_matcher_assert.svh =====
// assertion helpers, clocked on clk_i and disabled while rst_ni is low
`ifndef AHO_CORASICK_MATCHER_ASSERT_SVH
`define AHO_CORASICK_MATCHER_ASSERT_SVH

// condition holds at every edge
`define AHO_ASSERT(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("aho assertion failed");

// condition in one cycle implies a condition in the next
`define AHO_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("aho assertion failed");

`endif

// ===== src/aho_pkg.sv =====
`default_nettype none
package aho_pkg;

  localparam int unsigned ALPHABET_DEF     = 26;
  localparam int unsigned MAX_NODES_DEF    = 256;
  localparam int unsigned MAX_PATTERNS_DEF = 64;
  localparam int unsigned MAX_RESULTS      = 64;
  localparam int unsigned QUEUE_DEPTH      = 2;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_END   = 2'd1,
    OP_BUILD = 2'd2,
    OP_SCAN  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NODE_FULL   = 2'd1,
    ST_PAT_FULL    = 2'd2,
    ST_WRONG_PHASE = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [4:0]  symbol;
    logic [15:0] pattern_index;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        match_found;
    logic [15:0] matched_index;
    logic        last;
  } out_t;

  // classified request handed from front to back
  typedef struct packed {
    op_e         op;
    logic        sym_ok;
    logic [4:0]  symbol;
    logic [15:0] pattern_index;
  } cmd_t;

endpackage
`default_nettype wire

// ===== src/aho_corasick_matcher.sv =====
// channel   | handshake           | payload
// request   | push / full         | req_i (operation, symbol, pattern_index)
// result    | pop / empty         | rsp_o (status, match_found, matched_index, last)
//
// after reset all MAX_NODES*ALPHABET goto entries (6656 by default) are swept, full high
// load passes S_LD and end passes S_END before S_RES, an ignored or rejected request goes to S_RES
// scan reads goto in S_SGO (not for a letter outside the alphabet), then each node on the
// terminal chain passes S_SNODE, S_SHEAD and S_SSLOT, each match S_SEMIT, and last S_SDONE
// build visits each trie node breadth first, one goto read per letter and step
// a full result queue stalls the back end, a full request queue raises full
`default_nettype none
module aho_corasick_matcher #(
  parameter int unsigned ALPHABET     = aho_pkg::ALPHABET_DEF,
  parameter int unsigned MAX_NODES    = aho_pkg::MAX_NODES_DEF,
  parameter int unsigned MAX_PATTERNS = aho_pkg::MAX_PATTERNS_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push,
  input  wire aho_pkg::in_t  req_i,
  output logic               full,
  output logic               empty,
  input  wire logic          pop,
  output aho_pkg::out_t      rsp_o
);

  logic          cmd_valid, cmd_pop, busy;
  aho_pkg::cmd_t cmd;
  logic          out_push, out_full;
  aho_pkg::out_t out_data;
  logic [$bits(aho_pkg::out_t)-1:0] rsp_raw;

  aho_front #(.ALPHABET(ALPHABET)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .req_i      (req_i),
    .full_o     (full),
    .busy_i     (busy),
    .cmd_valid_o(cmd_valid),
    .cmd_pop_i  (cmd_pop),
    .cmd_o      (cmd)
  );

  aho_back #(
    .ALPHABET    (ALPHABET),
    .MAX_NODES   (MAX_NODES),
    .MAX_PATTERNS(MAX_PATTERNS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .cmd_pop_o  (cmd_pop),
    .busy_o     (busy),
    .out_push_o (out_push),
    .out_data_o (out_data),
    .out_full_i (out_full)
  );

  aho_fifo #(
    .WIDTH($bits(aho_pkg::out_t)),
    .DEPTH(aho_pkg::QUEUE_DEPTH)
  ) u_rsp_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (out_push),
    .data_i (out_data),
    .full_o (out_full),
    .pop_i  (pop),
    .data_o (rsp_raw),
    .empty_o(empty)
  );

  assign rsp_o = aho_pkg::out_t'(rsp_raw);

endmodule
`default_nettype wire

// ===== src/aho_ram.sv =====
`default_nettype none
module aho_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== src/aho_fifo.sv =====
`default_nettype none
module aho_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned PW = $clog2(DEPTH),
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] data_o,
  output logic                  empty_o
);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = slot_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

// ===== src/aho_front.sv =====
`default_nettype none
module aho_front #(
  parameter int unsigned ALPHABET = aho_pkg::ALPHABET_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire aho_pkg::in_t  req_i,
  output logic               full_o,
  input  wire logic          busy_i,
  output logic               cmd_valid_o,
  input  wire logic          cmd_pop_i,
  output aho_pkg::cmd_t      cmd_o
);

  aho_pkg::cmd_t cmd_in;
  logic          q_full, q_empty;
  logic [$bits(aho_pkg::cmd_t)-1:0] q_rdata;

  // decode the request and check the letter against the alphabet
  always_comb begin
    cmd_in.op            = aho_pkg::op_e'(req_i.operation);
    cmd_in.sym_ok        = (int'(req_i.symbol) < int'(ALPHABET));
    cmd_in.symbol        = req_i.symbol;
    cmd_in.pattern_index = req_i.pattern_index;
  end

  assign full_o = q_full || busy_i;

  aho_fifo #(
    .WIDTH($bits(aho_pkg::cmd_t)),
    .DEPTH(aho_pkg::QUEUE_DEPTH)
  ) u_cmd_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i && !full_o),
    .data_i (cmd_in),
    .full_o (q_full),
    .pop_i  (cmd_pop_i),
    .data_o (q_rdata),
    .empty_o(q_empty)
  );

  assign cmd_valid_o = !q_empty;
  assign cmd_o       = aho_pkg::cmd_t'(q_rdata);

endmodule
`default_nettype wire

// ===== src/aho_back.sv =====
`default_nettype none
`include "aho_corasick_matcher_assert.svh"
module aho_back #(
  parameter int unsigned ALPHABET     = aho_pkg::ALPHABET_DEF,
  parameter int unsigned MAX_NODES    = aho_pkg::MAX_NODES_DEF,
  parameter int unsigned MAX_PATTERNS = aho_pkg::MAX_PATTERNS_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_valid_i,
  input  wire aho_pkg::cmd_t cmd_i,
  output logic               cmd_pop_o,
  output logic               busy_o,
  output logic               out_push_o,
  output aho_pkg::out_t      out_data_o,
  input  wire logic          out_full_i
);

  localparam int unsigned NW  = $clog2(MAX_NODES);
  localparam int unsigned NW1 = NW + 1;
  localparam int unsigned LW  = $clog2(ALPHABET);
  localparam int unsigned GD  = MAX_NODES * ALPHABET;
  localparam int unsigned GW  = $clog2(GD);
  localparam int unsigned SW  = $clog2(MAX_PATTERNS + 1);
  localparam int unsigned SIW = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
  localparam int unsigned KW  = $clog2(aho_pkg::MAX_RESULTS + 1);
  localparam logic [SW-1:0]  NO_SLOT = SW'(MAX_PATTERNS);
  localparam logic [NW1-1:0] NO_NODE = NW1'(MAX_NODES);

  typedef enum logic [18:0] {
    S_CLR   = 19'h00001,
    S_IDLE  = 19'h00002,
    S_LD    = 19'h00004,
    S_END   = 19'h00008,
    S_POP   = 19'h00010,
    S_CUR   = 19'h00020,
    S_KIDS  = 19'h00040,
    S_SUF   = 19'h00080,
    S_SFR   = 19'h00100,
    S_SF    = 19'h00200,
    S_FILL  = 19'h00400,
    S_TRW   = 19'h00800,
    S_SGO   = 19'h01000,
    S_SNODE = 19'h02000,
    S_SHEAD = 19'h04000,
    S_SSLOT = 19'h08000,
    S_SEMIT = 19'h10000,
    S_SDONE = 19'h20000,
    S_RES   = 19'h40000
  } state_e;

  function automatic logic [GW-1:0] gaddr(input logic [NW-1:0] n, input logic [LW-1:0] a);
    gaddr = GW'(GW'(n) * GW'(ALPHABET)) + GW'(a);
  endfunction

  state_e           state_q, state_d;
  logic [GW:0]      clr_q, clr_d;
  logic [NW1-1:0]   nodes_q, nodes_d;
  logic [SW-1:0]    slots_q, slots_d;
  logic [NW-1:0]    cursor_q, cursor_d, scan_q, scan_d;
  logic             built_q, built_d;
  aho_pkg::status_e st_q, st_d;
  aho_pkg::cmd_t    cmd_q, cmd_d;
  logic [NW1-1:0]   head_q, head_d, tail_q, tail_d;
  logic [NW-1:0]    cur_q, cur_d, sf_q, sf_d;
  logic [LW-1:0]    edge_q, edge_d, dix_q, dix_d;
  logic [LW:0]      cnt_q, cnt_d;
  logic             p_q, p_d;
  logic [NW1-1:0]   v_q, v_d, nextv_q, nextv_d, guard_q, guard_d;
  logic [SW-1:0]    s_q, s_d;
  logic [SIW-1:0]   snew_q, snew_d;
  logic [KW-1:0]    k_q, k_d;
  logic             pend_q, pend_d;
  logic [15:0]      pidx_q, pidx_d;

  // memory ports
  logic           g_we, ga_re, gb_re;
  logic [GW-1:0]  g_waddr, ga_raddr, gb_raddr;
  logic [NW:0]    g_wdata, ga_rdata, gb_rdata;
  logic           suf_we, suf_re;
  logic [NW-1:0]  suf_waddr, suf_raddr, suf_wdata, suf_rdata;
  logic           trm_we, trm_re;
  logic [NW-1:0]  trm_waddr, trm_raddr;
  logic [NW1-1:0] trm_wdata, trm_rdata;
  logic           par_we, par_re;
  logic [NW-1:0]  par_addr, par_wdata, par_rdata;
  logic [LW-1:0]  edg_wdata, edg_rdata;
  logic           fst_we, fst_re;
  logic [NW-1:0]  fst_waddr, fst_raddr;
  logic [SW-1:0]  fst_wdata, fst_rdata;
  logic           fin_we, fin_re;
  logic [NW-1:0]  fin_waddr, fin_raddr;
  logic [SW-1:0]  fin_rdata;
  logic           id_we, sl_re;
  logic [SIW-1:0] id_waddr, sl_raddr, suc_waddr;
  logic [15:0]    id_rdata;
  logic           suc_we;
  logic [SW-1:0]  suc_wdata, suc_rdata;
  logic           bfs_we, bfs_re;
  logic [NW-1:0]  bfs_waddr, bfs_raddr, bfs_wdata, bfs_rdata;
  logic [NW-1:0]  g_node;
  logic [LW-1:0]  cmd_sym, cnt_ix;

  assign busy_o  = (state_q == S_CLR);
  assign cmd_sym = LW'(cmd_q.symbol);
  assign cnt_ix  = cnt_q[LW-1:0];
  assign g_node  = ga_rdata[NW-1:0];

  always_comb begin
    state_d = state_q;  clr_d = clr_q;     nodes_d = nodes_q;   slots_d = slots_q;
    cursor_d = cursor_q; scan_d = scan_q;  built_d = built_q;   st_d = st_q;
    cmd_d = cmd_q;      head_d = head_q;   tail_d = tail_q;     cur_d = cur_q;
    sf_d = sf_q;        edge_d = edge_q;   dix_d = dix_q;       cnt_d = cnt_q;
    p_d = p_q;          v_d = v_q;         nextv_d = nextv_q;   guard_d = guard_q;
    s_d = s_q;          snew_d = snew_q;   k_d = k_q;           pend_d = pend_q;
    pidx_d = pidx_q;
    cmd_pop_o = 1'b0;   out_push_o = 1'b0; out_data_o = '0;
    g_we = 1'b0;   g_waddr = '0;  g_wdata = '0;
    ga_re = 1'b0;  ga_raddr = '0; gb_re = 1'b0; gb_raddr = '0;
    suf_we = 1'b0; suf_waddr = '0; suf_wdata = '0; suf_re = 1'b0; suf_raddr = '0;
    trm_we = 1'b0; trm_waddr = '0; trm_wdata = '0; trm_re = 1'b0; trm_raddr = '0;
    par_we = 1'b0; par_re = 1'b0; par_addr = '0; par_wdata = '0; edg_wdata = '0;
    fst_we = 1'b0; fst_waddr = '0; fst_wdata = '0; fst_re = 1'b0; fst_raddr = '0;
    fin_we = 1'b0; fin_waddr = '0; fin_re = 1'b0; fin_raddr = '0;
    id_we = 1'b0;  id_waddr = '0;  sl_re = 1'b0;  sl_raddr = '0;
    suc_we = 1'b0; suc_waddr = '0; suc_wdata = '0;
    bfs_we = 1'b0; bfs_waddr = '0; bfs_wdata = '0; bfs_re = 1'b0; bfs_raddr = '0;

    case (state_q)
      S_CLR: begin
        g_we    = 1'b1;
        g_waddr = clr_q[GW-1:0];
        if (clr_q < (GW+1)'(MAX_NODES)) begin
          fst_we    = 1'b1;
          fst_waddr = clr_q[NW-1:0];
          fst_wdata = NO_SLOT;
        end
        clr_d = clr_q + (GW+1)'(1);
        if (clr_q == (GW+1)'(GD - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          st_d      = aho_pkg::ST_OK;
          state_d   = S_RES;
          case (cmd_i.op)
            aho_pkg::OP_LOAD: begin
              if (built_q) begin
                st_d = aho_pkg::ST_WRONG_PHASE;
              end else if (cmd_i.sym_ok) begin
                ga_re    = 1'b1;
                ga_raddr = gaddr(cursor_q, LW'(cmd_i.symbol));
                state_d  = S_LD;
              end
            end
            aho_pkg::OP_END: begin
              if (built_q) begin
                st_d = aho_pkg::ST_WRONG_PHASE;
              end else begin
                cursor_d = '0;
                cur_d    = cursor_q;
                if (slots_q >= NO_SLOT) begin
                  st_d = aho_pkg::ST_PAT_FULL;
                end else begin
                  id_we     = 1'b1;
                  id_waddr  = slots_q[SIW-1:0];
                  suc_we    = 1'b1;
                  suc_waddr = slots_q[SIW-1:0];
                  suc_wdata = NO_SLOT;
                  fst_re    = 1'b1;
                  fst_raddr = cursor_q;
                  fin_re    = 1'b1;
                  fin_raddr = cursor_q;
                  snew_d    = slots_q[SIW-1:0];
                  slots_d   = slots_q + SW'(1);
                  state_d   = S_END;
                end
              end
            end
            aho_pkg::OP_BUILD: begin
              if (!built_q) begin
                bfs_we    = 1'b1;
                bfs_waddr = '0;
                bfs_wdata = '0;
                head_d    = '0;
                tail_d    = NW1'(1);
                state_d   = S_POP;
              end
            end
            aho_pkg::OP_SCAN: begin
              if (!built_q) begin
                st_d = aho_pkg::ST_WRONG_PHASE;
              end else begin
                k_d     = '0;
                pend_d  = 1'b0;
                guard_d = '0;
                if (cmd_i.sym_ok) begin
                  ga_re    = 1'b1;
                  ga_raddr = gaddr(scan_q, LW'(cmd_i.symbol));
                  state_d  = S_SGO;
                end else begin
                  scan_d  = '0;
                  v_d     = '0;
                  state_d = S_SNODE;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_LD: begin
        state_d = S_RES;
        if (ga_rdata[NW]) begin
          cursor_d = g_node;
        end else if (nodes_q >= NW1'(MAX_NODES)) begin
          st_d = aho_pkg::ST_NODE_FULL;
        end else begin
          g_we      = 1'b1;
          g_waddr   = gaddr(cursor_q, cmd_sym);
          g_wdata   = {1'b1, nodes_q[NW-1:0]};
          par_we    = 1'b1;
          par_addr  = nodes_q[NW-1:0];
          par_wdata = cursor_q;
          edg_wdata = cmd_sym;
          fst_we    = 1'b1;
          fst_waddr = nodes_q[NW-1:0];
          fst_wdata = NO_SLOT;
          cursor_d  = nodes_q[NW-1:0];
          nodes_d   = nodes_q + NW1'(1);
        end
      end
      S_END: begin
        if (fst_rdata == NO_SLOT) begin
          fst_we    = 1'b1;
          fst_waddr = cur_q;
          fst_wdata = SW'(snew_q);
        end else begin
          suc_we    = 1'b1;
          suc_waddr = fin_rdata[SIW-1:0];
          suc_wdata = SW'(snew_q);
        end
        fin_we    = 1'b1;
        fin_waddr = cur_q;
        state_d   = S_RES;
      end
      S_POP: begin
        if (head_q == tail_q) begin
          built_d = 1'b1;
          state_d = S_RES;
        end else begin
          bfs_re    = 1'b1;
          bfs_raddr = head_q[NW-1:0];
          head_d    = head_q + NW1'(1);
          state_d   = S_CUR;
        end
      end
      S_CUR: begin
        cur_d   = bfs_rdata;
        cnt_d   = '0;
        p_d     = 1'b0;
        state_d = S_KIDS;
      end
      S_KIDS: begin
        // children present before this node is filled go to the queue
        if (cnt_q < (LW+1)'(ALPHABET)) begin
          ga_re    = 1'b1;
          ga_raddr = gaddr(cur_q, cnt_ix);
          cnt_d    = cnt_q + (LW+1)'(1);
        end
        p_d = (cnt_q < (LW+1)'(ALPHABET));
        if (p_q && ga_rdata[NW] && tail_q < NW1'(MAX_NODES)) begin
          bfs_we    = 1'b1;
          bfs_waddr = tail_q[NW-1:0];
          bfs_wdata = g_node;
          tail_d    = tail_q + NW1'(1);
        end
        if (cnt_q == (LW+1)'(ALPHABET) && !p_q) begin
          cnt_d = '0;
          p_d   = 1'b0;
          if (cur_q == '0) begin
            sf_d    = '0;
            state_d = S_FILL;
          end else begin
            par_re   = 1'b1;
            par_addr = cur_q;
            state_d  = S_SUF;
          end
        end
      end
      S_SUF: begin
        suf_re    = 1'b1;
        suf_raddr = par_rdata;
        edge_d    = edg_rdata;
        state_d   = S_SFR;
      end
      S_SFR: begin
        ga_re    = 1'b1;
        ga_raddr = gaddr(suf_rdata, edge_q);
        state_d  = S_SF;
      end
      S_SF: begin
        sf_d      = (g_node == cur_q) ? '0 : g_node;
        suf_we    = 1'b1;
        suf_waddr = cur_q;
        suf_wdata = (g_node == cur_q) ? '0 : g_node;
        cnt_d     = '0;
        p_d       = 1'b0;
        state_d   = S_FILL;
      end
      S_FILL: begin
        if (cnt_q < (LW+1)'(ALPHABET)) begin
          ga_re    = 1'b1;
          ga_raddr = gaddr(cur_q, cnt_ix);
          gb_re    = 1'b1;
          gb_raddr = gaddr(sf_q, cnt_ix);
          dix_d    = cnt_ix;
          cnt_d    = cnt_q + (LW+1)'(1);
        end
        p_d = (cnt_q < (LW+1)'(ALPHABET));
        if (p_q && !ga_rdata[NW]) begin
          g_we    = 1'b1;
          g_waddr = gaddr(cur_q, dix_q);
          g_wdata = {1'b1, (cur_q == '0) ? NW'(0) : gb_rdata[NW-1:0]};
        end
        if (cnt_q == (LW+1)'(ALPHABET) && !p_q) begin
          if (cur_q == '0) begin
            suf_we    = 1'b1;
            suf_waddr = '0;
            suf_wdata = '0;
            trm_we    = 1'b1;
            trm_waddr = '0;
            trm_wdata = NO_NODE;
            state_d   = S_POP;
          end else begin
            fst_re    = 1'b1;
            fst_raddr = sf_q;
            trm_re    = 1'b1;
            trm_raddr = sf_q;
            state_d   = S_TRW;
          end
        end
      end
      S_TRW: begin
        trm_we    = 1'b1;
        trm_waddr = cur_q;
        trm_wdata = (fst_rdata != NO_SLOT) ? NW1'(sf_q) : trm_rdata;
        state_d   = S_POP;
      end
      S_SGO: begin
        scan_d  = g_node;
        v_d     = NW1'(g_node);
        state_d = S_SNODE;
      end
      S_SNODE: begin
        if (v_q >= NW1'(MAX_NODES) || guard_q >= NW1'(MAX_NODES)) begin
          state_d = S_SDONE;
        end else begin
          fst_re    = 1'b1;
          fst_raddr = v_q[NW-1:0];
          trm_re    = 1'b1;
          trm_raddr = v_q[NW-1:0];
          guard_d   = guard_q + NW1'(1);
          state_d   = S_SHEAD;
        end
      end
      S_SHEAD: begin
        s_d     = fst_rdata;
        nextv_d = trm_rdata;
        state_d = S_SSLOT;
      end
      S_SSLOT: begin
        if (s_q < NO_SLOT && k_q < KW'(aho_pkg::MAX_RESULTS)) begin
          sl_re    = 1'b1;
          sl_raddr = s_q[SIW-1:0];
          state_d  = S_SEMIT;
        end else begin
          v_d     = nextv_q;
          state_d = S_SNODE;
        end
      end
      S_SEMIT: begin
        // hold one match back so the last one can carry the last flag
        if (!(pend_q && out_full_i)) begin
          if (pend_q) begin
            out_push_o               = 1'b1;
            out_data_o.status        = aho_pkg::ST_OK;
            out_data_o.match_found   = 1'b1;
            out_data_o.matched_index = pidx_q;
          end
          pend_d  = 1'b1;
          pidx_d  = id_rdata;
          k_d     = k_q + KW'(1);
          s_d     = suc_rdata;
          state_d = S_SSLOT;
        end
      end
      S_SDONE: begin
        if (!out_full_i) begin
          out_push_o               = 1'b1;
          out_data_o.status        = aho_pkg::ST_OK;
          out_data_o.match_found   = pend_q;
          out_data_o.matched_index = pend_q ? pidx_q : 16'd0;
          out_data_o.last          = 1'b1;
          state_d                  = S_IDLE;
        end
      end
      S_RES: begin
        if (!out_full_i) begin
          out_push_o        = 1'b1;
          out_data_o.status = st_q;
          out_data_o.last   = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      clr_q    <= '0;
      nodes_q  <= NW1'(1);
      slots_q  <= '0;
      cursor_q <= '0;
      scan_q   <= '0;
      built_q  <= 1'b0;
      head_q   <= '0;
      tail_q   <= '0;
      cnt_q    <= '0;
      p_q      <= 1'b0;
      pend_q   <= 1'b0;
      k_q      <= '0;
      guard_q  <= '0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      nodes_q  <= nodes_d;
      slots_q  <= slots_d;
      cursor_q <= cursor_d;
      scan_q   <= scan_d;
      built_q  <= built_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      cnt_q    <= cnt_d;
      p_q      <= p_d;
      pend_q   <= pend_d;
      k_q      <= k_d;
      guard_q  <= guard_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q    <= st_d;
    cmd_q   <= cmd_d;
    cur_q   <= cur_d;
    sf_q    <= sf_d;
    edge_q  <= edge_d;
    dix_q   <= dix_d;
    v_q     <= v_d;
    nextv_q <= nextv_d;
    s_q     <= s_d;
    snew_q  <= snew_d;
    pidx_q  <= pidx_d;
  end

  // goto table kept twice so a fill step reads its own row and the suffix row at once
  aho_ram #(.WIDTH(NW + 1), .DEPTH(GD)) u_goto_a (
    .clk_i(clk_i), .we_i(g_we), .waddr_i(g_waddr), .wdata_i(g_wdata),
    .re_i(ga_re), .raddr_i(ga_raddr), .rdata_o(ga_rdata)
  );
  aho_ram #(.WIDTH(NW + 1), .DEPTH(GD)) u_goto_b (
    .clk_i(clk_i), .we_i(g_we), .waddr_i(g_waddr), .wdata_i(g_wdata),
    .re_i(gb_re), .raddr_i(gb_raddr), .rdata_o(gb_rdata)
  );
  aho_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_suffix (
    .clk_i(clk_i), .we_i(suf_we), .waddr_i(suf_waddr), .wdata_i(suf_wdata),
    .re_i(suf_re), .raddr_i(suf_raddr), .rdata_o(suf_rdata)
  );
  aho_ram #(.WIDTH(NW1), .DEPTH(MAX_NODES)) u_term (
    .clk_i(clk_i), .we_i(trm_we), .waddr_i(trm_waddr), .wdata_i(trm_wdata),
    .re_i(trm_re), .raddr_i(trm_raddr), .rdata_o(trm_rdata)
  );
  aho_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_parent (
    .clk_i(clk_i), .we_i(par_we), .waddr_i(par_addr), .wdata_i(par_wdata),
    .re_i(par_re), .raddr_i(par_addr), .rdata_o(par_rdata)
  );
  aho_ram #(.WIDTH(LW), .DEPTH(MAX_NODES)) u_edge (
    .clk_i(clk_i), .we_i(par_we), .waddr_i(par_addr), .wdata_i(edg_wdata),
    .re_i(par_re), .raddr_i(par_addr), .rdata_o(edg_rdata)
  );
  aho_ram #(.WIDTH(SW), .DEPTH(MAX_NODES)) u_first (
    .clk_i(clk_i), .we_i(fst_we), .waddr_i(fst_waddr), .wdata_i(fst_wdata),
    .re_i(fst_re), .raddr_i(fst_raddr), .rdata_o(fst_rdata)
  );
  aho_ram #(.WIDTH(SW), .DEPTH(MAX_NODES)) u_final (
    .clk_i(clk_i), .we_i(fin_we), .waddr_i(fin_waddr), .wdata_i(SW'(snew_q)),
    .re_i(fin_re), .raddr_i(fin_raddr), .rdata_o(fin_rdata)
  );
  aho_ram #(.WIDTH(16), .DEPTH(MAX_PATTERNS)) u_slot_id (
    .clk_i(clk_i), .we_i(id_we), .waddr_i(id_waddr), .wdata_i(cmd_i.pattern_index),
    .re_i(sl_re), .raddr_i(sl_raddr), .rdata_o(id_rdata)
  );
  aho_ram #(.WIDTH(SW), .DEPTH(MAX_PATTERNS)) u_slot_next (
    .clk_i(clk_i), .we_i(suc_we), .waddr_i(suc_waddr), .wdata_i(suc_wdata),
    .re_i(sl_re), .raddr_i(sl_raddr), .rdata_o(suc_rdata)
  );
  aho_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_bfs (
    .clk_i(clk_i), .we_i(bfs_we), .waddr_i(bfs_waddr), .wdata_i(bfs_wdata),
    .re_i(bfs_re), .raddr_i(bfs_raddr), .rdata_o(bfs_rdata)
  );

  `AHO_ASSERT(a_node_count, nodes_q != '0 && nodes_q <= NW1'(MAX_NODES))
  `AHO_ASSERT(a_no_push_full, !(out_push_o && out_full_i))
  `AHO_ASSERT_NEXT(a_built_sticky, built_q, built_q)
  `AHO_ASSERT(a_bfs_order, head_q <= tail_q)
  `AHO_ASSERT(a_no_take_clear, !(state_q == S_CLR && cmd_pop_o))

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ALPH    = aho_pkg::ALPHABET_DEF;
  localparam int unsigned NODES   = aho_pkg::MAX_NODES_DEF;
  localparam int unsigned PATS    = aho_pkg::MAX_PATTERNS_DEF;
  localparam int unsigned NO_SLOT = PATS;
  localparam int unsigned NO_NODE = NODES;
  localparam int unsigned ROOT    = 0;
  localparam int unsigned CYCLE_LIMIT  = 3000000;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned EXP_CAP      = 4096;
  localparam int unsigned ITEM_CAP     = 1024;

  typedef struct packed {
    aho_pkg::op_e     op;
    logic [4:0]       sym;
    logic [15:0]      pid;
    logic             typed;
    aho_pkg::status_e st;
  } row_t;

  logic          clk_i;
  logic          rst_ni;
  logic          push;
  aho_pkg::in_t  req_i;
  logic          full;
  logic          empty;
  logic          pop;
  aho_pkg::out_t rsp_o;

  aho_corasick_matcher u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push   (push),
    .req_i  (req_i),
    .full   (full),
    .empty  (empty),
    .pop    (pop),
    .rsp_o  (rsp_o)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // shadow automaton
  int unsigned goto_nxt [NODES*ALPH];
  bit          goto_ok  [NODES*ALPH];
  int unsigned fail_lnk [NODES];
  int unsigned term_lnk [NODES];
  int unsigned parent   [NODES];
  int unsigned letter   [NODES];
  int unsigned head_slot[NODES];
  int unsigned tail_slot[NODES];
  int unsigned slot_pid [PATS];
  int unsigned slot_nxt [PATS];
  int unsigned node_cnt;
  int unsigned slot_cnt;
  int unsigned trie_pos;
  int unsigned scan_pos;
  bit          links_done;

  // expected results, oldest at exp_rd
  aho_pkg::out_t exp_buf [EXP_CAP];
  int unsigned   exp_wr;
  int unsigned   exp_rd;
  // per-request override for rows with a hand-written result
  bit            typed_use [ITEM_CAP];
  aho_pkg::out_t typed_rsp [ITEM_CAP];

  row_t pre_rows  [17];
  row_t post_rows [11];

  int unsigned errors;
  int unsigned cycles;
  int unsigned reqs_taken;
  int unsigned rsps_seen;
  int unsigned matches_seen;
  int unsigned nomatch_seen;
  bit          req_taken;
  bit          rsp_taken;

  function automatic aho_pkg::out_t mk_rsp(aho_pkg::status_e st, bit mf, logic [15:0] idx,
                                           bit lst);
    aho_pkg::out_t r;
    r.status        = st;
    r.match_found   = mf;
    r.matched_index = idx;
    r.last          = lst;
    return r;
  endfunction

  function automatic row_t mk_row(aho_pkg::op_e op, logic [4:0] sym, logic [15:0] pid,
                                  bit typed = 1'b0, aho_pkg::status_e st = aho_pkg::ST_OK);
    row_t w;
    w.op    = op;
    w.sym   = sym;
    w.pid   = pid;
    w.typed = typed;
    w.st    = st;
    return w;
  endfunction

  function automatic void exp_put(aho_pkg::out_t r);
    exp_buf[exp_wr % EXP_CAP] = r;
    exp_wr++;
  endfunction

  function automatic void build_links();
    int unsigned q[NODES];
    int unsigned hd;
    int unsigned tl;
    int unsigned cur;
    int unsigned sf;
    hd = 0;
    tl = 0;
    q[tl++] = ROOT;
    while (hd < tl) begin
      cur = q[hd++];
      for (int a = 0; a < ALPH; a++) begin
        if (goto_ok[cur*ALPH+a] && tl < NODES) q[tl++] = goto_nxt[cur*ALPH+a];
      end
      if (cur == ROOT) begin
        for (int a = 0; a < ALPH; a++) begin
          if (!goto_ok[a]) begin
            goto_nxt[a] = ROOT;
            goto_ok[a]  = 1'b1;
          end
        end
        fail_lnk[ROOT] = ROOT;
        term_lnk[ROOT] = NO_NODE;
      end else begin
        sf = goto_nxt[fail_lnk[parent[cur]]*ALPH + letter[cur]];
        if (sf == cur) sf = ROOT;
        fail_lnk[cur] = sf;
        for (int a = 0; a < ALPH; a++) begin
          if (!goto_ok[cur*ALPH+a]) begin
            goto_nxt[cur*ALPH+a] = goto_nxt[sf*ALPH+a];
            goto_ok[cur*ALPH+a]  = 1'b1;
          end
        end
        term_lnk[cur] = (head_slot[sf] != NO_SLOT) ? sf : term_lnk[sf];
      end
    end
    links_done = 1'b1;
  endfunction

  // appends the results one request produces to the expected buffer
  function automatic void automaton_step(aho_pkg::in_t it);
    int unsigned sym;
    int unsigned e;
    int unsigned c;
    int unsigned s;
    int unsigned v;
    int unsigned k;
    int unsigned guard;
    aho_pkg::status_e st;
    aho_pkg::out_t r;
    sym = it.symbol;
    st  = aho_pkg::ST_OK;
    case (aho_pkg::op_e'(it.operation))
      aho_pkg::OP_LOAD: begin
        if (links_done) st = aho_pkg::ST_WRONG_PHASE;
        else if (sym < ALPH) begin
          e = trie_pos*ALPH + sym;
          if (goto_ok[e]) trie_pos = goto_nxt[e];
          else if (node_cnt >= NODES) st = aho_pkg::ST_NODE_FULL;
          else begin
            goto_nxt[e] = node_cnt;
            goto_ok[e]  = 1'b1;
            parent[node_cnt]    = trie_pos;
            letter[node_cnt]    = sym;
            head_slot[node_cnt] = NO_SLOT;
            trie_pos = node_cnt;
            node_cnt++;
          end
        end
      end
      aho_pkg::OP_END: begin
        if (links_done) st = aho_pkg::ST_WRONG_PHASE;
        else begin
          c = trie_pos;
          trie_pos = ROOT;
          if (slot_cnt >= PATS) st = aho_pkg::ST_PAT_FULL;
          else begin
            s = slot_cnt++;
            slot_pid[s] = it.pattern_index;
            slot_nxt[s] = NO_SLOT;
            if (head_slot[c] == NO_SLOT) head_slot[c] = s;
            else slot_nxt[tail_slot[c]] = s;
            tail_slot[c] = s;
          end
        end
      end
      aho_pkg::OP_BUILD: begin
        if (!links_done) build_links();
      end
      default: begin
        if (!links_done) st = aho_pkg::ST_WRONG_PHASE;
        else begin
          scan_pos = (sym < ALPH) ? goto_nxt[scan_pos*ALPH + sym] : ROOT;
          v = scan_pos;
          k = 0;
          guard = 0;
          while (v != NO_NODE && v < NODES && guard < NODES) begin
            s = head_slot[v];
            while (s != NO_SLOT && s < PATS && k < aho_pkg::MAX_RESULTS) begin
              if (k > 0) exp_put(r);
              r = mk_rsp(aho_pkg::ST_OK, 1'b1, slot_pid[s][15:0], 1'b0);
              k++;
              s = slot_nxt[s];
            end
            v = term_lnk[v];
            guard++;
          end
          if (k == 0) r = mk_rsp(aho_pkg::ST_OK, 1'b0, 16'd0, 1'b1);
          else r.last = 1'b1;
          exp_put(r);
          return;
        end
      end
    endcase
    exp_put(mk_rsp(st, 1'b0, 16'd0, 1'b1));
  endfunction

  // request and result monitor, samples at the rising edge
  always @(posedge clk_i) begin
    aho_pkg::out_t want;
    cycles++;
    req_taken = 1'b0;
    rsp_taken = 1'b0;
    if (rst_ni && push && !full) begin
      req_taken = 1'b1;
      automaton_step(req_i);
      if (typed_use[reqs_taken % ITEM_CAP]) begin
        exp_buf[(exp_wr - 1) % EXP_CAP] = typed_rsp[reqs_taken % ITEM_CAP];
      end
      reqs_taken++;
    end
    if (rst_ni && pop && !empty) begin
      rsp_taken = 1'b1;
      rsps_seen++;
      if (rsp_o.match_found) matches_seen++;
      else nomatch_seen++;
      if (exp_wr == exp_rd) begin
        errors++;
        if (errors <= 10) $display("unexpected result: st=%0d mf=%0b idx=%h last=%0b",
                                   rsp_o.status, rsp_o.match_found, rsp_o.matched_index,
                                   rsp_o.last);
      end else begin
        want = exp_buf[exp_rd % EXP_CAP];
        exp_rd++;
        if (rsp_o.status !== want.status || rsp_o.match_found !== want.match_found ||
            rsp_o.matched_index !== want.matched_index || rsp_o.last !== want.last) begin
          errors++;
          if (errors <= 10)
            $display("mismatch at result %0d: exp st=%0d mf=%0b idx=%h last=%0b, %s",
                     rsps_seen, want.status, want.match_found, want.matched_index, want.last,
                     $sformatf("got st=%0d mf=%0b idx=%h last=%0b", rsp_o.status,
                               rsp_o.match_found, rsp_o.matched_index, rsp_o.last));
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side
  initial begin
    int unsigned gap;
    bit held;
    held = 1'b0;
    pop  = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!held && rsps_seen >= 100) begin
        held = 1'b1;
        gap  = 400;
      end else if (rsps_seen >= 40 && rsps_seen < 80) gap = 0;
      else gap = $urandom_range(0, 5);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      pop <= 1'b1;
      do @(negedge clk_i); while (!rsp_taken);
    end
  end

  int unsigned sent;

  task automatic send(aho_pkg::op_e op, logic [4:0] sym, logic [15:0] pid, bit typed = 1'b0,
                      aho_pkg::status_e st = aho_pkg::ST_OK);
    int unsigned gap;
    aho_pkg::in_t it;
    it.operation     = op;
    it.symbol        = sym;
    it.pattern_index = pid;
    gap = (sent >= 200 && sent < 260) ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    typed_use[sent % ITEM_CAP] = typed;
    typed_rsp[sent % ITEM_CAP] = mk_rsp(st, 1'b0, 16'd0, 1'b1);
    push  <= 1'b1;
    req_i <= it;
    do @(negedge clk_i); while (!req_taken);
    sent++;
  endtask

  task automatic send_row(row_t w);
    send(w.op, w.sym, w.pid, w.typed, w.st);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (exp_wr != exp_rd) @(negedge clk_i);
  endtask

  function automatic logic [4:0] pick_letter(bit narrow);
    return narrow ? 5'($urandom_range(0, 3)) : 5'($urandom_range(0, ALPH-1));
  endfunction

  initial begin
    int unsigned len;
    int unsigned sel;
    bit narrow;
    errors = 0;
    cycles = 0;
    sent = 0;
    reqs_taken = 0;
    rsps_seen = 0;
    matches_seen = 0;
    nomatch_seen = 0;
    req_taken = 1'b0;
    rsp_taken = 1'b0;
    exp_wr = 0;
    exp_rd = 0;
    node_cnt = 1;
    slot_cnt = 0;
    trie_pos = ROOT;
    scan_pos = ROOT;
    links_done = 1'b0;
    for (int i = 0; i < NODES*ALPH; i++) goto_ok[i] = 1'b0;
    for (int i = 0; i < NODES; i++) head_slot[i] = NO_SLOT;
    for (int i = 0; i < ITEM_CAP; i++) typed_use[i] = 1'b0;

    // directed, before the links exist
    pre_rows = '{
      mk_row(aho_pkg::OP_SCAN, 5'd0,  16'h0000, 1'b1, aho_pkg::ST_WRONG_PHASE),
      mk_row(aho_pkg::OP_LOAD, 5'd31, 16'h0000, 1'b1, aho_pkg::ST_OK),
      mk_row(aho_pkg::OP_LOAD, 5'd0,  16'h0000),
      mk_row(aho_pkg::OP_LOAD, 5'd1,  16'h0000),
      mk_row(aho_pkg::OP_END,  5'd0,  16'h0000, 1'b1, aho_pkg::ST_OK),
      mk_row(aho_pkg::OP_LOAD, 5'd1,  16'h0000),
      mk_row(aho_pkg::OP_END,  5'd31, 16'hFFFF),
      // empty pattern, matches on every letter
      mk_row(aho_pkg::OP_END,  5'd0,  16'h1234),
      mk_row(aho_pkg::OP_LOAD, 5'd25, 16'h0000),
      mk_row(aho_pkg::OP_LOAD, 5'd25, 16'h0000),
      mk_row(aho_pkg::OP_END,  5'd0,  16'hABCD),
      mk_row(aho_pkg::OP_LOAD, 5'd0,  16'h0000),
      mk_row(aho_pkg::OP_LOAD, 5'd1,  16'h0000),
      mk_row(aho_pkg::OP_LOAD, 5'd2,  16'h0000),
      mk_row(aho_pkg::OP_END,  5'd0,  16'h5555),
      mk_row(aho_pkg::OP_LOAD, 5'd2,  16'h0000),
      mk_row(aho_pkg::OP_END,  5'd0,  16'h00FF)
    };
    // directed, after the links exist
    post_rows = '{
      mk_row(aho_pkg::OP_BUILD, 5'd0,  16'h0000, 1'b1, aho_pkg::ST_OK),
      mk_row(aho_pkg::OP_BUILD, 5'd31, 16'hFFFF, 1'b1, aho_pkg::ST_OK),
      mk_row(aho_pkg::OP_LOAD,  5'd0,  16'h0000, 1'b1, aho_pkg::ST_WRONG_PHASE),
      mk_row(aho_pkg::OP_END,   5'd0,  16'hFFFF, 1'b1, aho_pkg::ST_WRONG_PHASE),
      mk_row(aho_pkg::OP_SCAN,  5'd31, 16'h0000),
      mk_row(aho_pkg::OP_SCAN,  5'd0,  16'h0000),
      mk_row(aho_pkg::OP_SCAN,  5'd1,  16'h0000),
      mk_row(aho_pkg::OP_SCAN,  5'd2,  16'h0000),
      mk_row(aho_pkg::OP_SCAN,  5'd25, 16'h0000),
      mk_row(aho_pkg::OP_SCAN,  5'd25, 16'h0000),
      mk_row(aho_pkg::OP_SCAN,  5'd30, 16'hFFFF)
    };

    rst_ni = 1'b0;
    push   = 1'b0;
    req_i  = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (pre_rows[i]) send_row(pre_rows[i]);

    // random short patterns, enough to overflow the pattern table
    for (int p = 0; p < 60; p++) begin
      narrow = 1'($urandom_range(0, 1));
      len = $urandom_range(0, 3);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 9) == 0)
          send(aho_pkg::OP_LOAD, 5'($urandom_range(ALPH, 31)), 16'($urandom));
        send(aho_pkg::OP_LOAD, pick_letter(narrow), 16'($urandom));
      end
      if ($urandom_range(0, 15) == 0) send(aho_pkg::OP_SCAN, 5'($urandom), 16'($urandom));
      send(aho_pkg::OP_END, 5'($urandom), 16'($urandom));
    end

    drain();

    foreach (post_rows[i]) send_row(post_rows[i]);

    // random text, mostly over the dense letters
    for (int i = 0; i < 65; i++) begin
      sel = $urandom_range(0, 19);
      case (sel)
        0:       send(aho_pkg::OP_LOAD,  5'($urandom), 16'($urandom));
        1:       send(aho_pkg::OP_END,   5'($urandom), 16'($urandom));
        2:       send(aho_pkg::OP_BUILD, 5'($urandom), 16'($urandom));
        3:       send(aho_pkg::OP_SCAN,  5'($urandom), 16'($urandom));
        4:       send(aho_pkg::OP_SCAN,  5'($urandom), 16'($urandom));
        default: send(aho_pkg::OP_SCAN,  pick_letter(1'b1), 16'($urandom));
      endcase
    end

    drain();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    $display("%0d requests, %0d results (%0d matches, %0d without match), %0d trie nodes",
             reqs_taken, rsps_seen, matches_seen, nomatch_seen, node_cnt);
    $display("covered both phases, wrong-phase requests, pattern table overflow, stalls on both sides");
    if (errors == 0 && exp_wr == exp_rd) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, exp_wr - exp_rd);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
+incdir+src
src/aho_pkg.sv
src/aho_ram.sv
src/aho_fifo.sv
src/aho_front.sv
src/aho_back.sv
src/aho_corasick_matcher.sv
dv/testbench.sv
